// ----- rtl/mmu_tlb_walk_access_check_core_assert.svh -----
// Assertion macros for the translation core.
`ifndef MMU_TLB_WALK_ACCESS_CHECK_CORE_ASSERT_SVH
`define MMU_TLB_WALK_ACCESS_CHECK_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MTW_ASSERT_IMP(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
// Implication checked in the cycle after the condition.
`define MTW_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`endif

// ----- rtl/mtw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_pkg
// Shared types, codes and constants of the translation core.
// ----------------------------------------------------------------------------
package mtw_pkg;
    localparam int TLB_ENTRIES_DEF = 64;

    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_DESC   = 2'd1;
    localparam logic [1:0] KIND_INV    = 2'd2;
    localparam logic [1:0] KIND_INVALL = 2'd3;

    localparam logic [2:0] PK_NONE  = 3'd0;
    localparam logic [2:0] PK_SMALL = 3'd1;
    localparam logic [2:0] PK_LARGE = 3'd2;
    localparam logic [2:0] PK_SECT  = 3'd3;
    localparam logic [2:0] PK_XSMALL = 3'd4;
    localparam logic [2:0] PK_TINY  = 3'd5;

    localparam logic [2:0] F_NONE   = 3'd0;
    localparam logic [2:0] F_STRANS = 3'd1;
    localparam logic [2:0] F_PTRANS = 3'd2;
    localparam logic [2:0] F_DOMAIN = 3'd3;
    localparam logic [2:0] F_SPERM  = 3'd4;
    localparam logic [2:0] F_PPERM  = 3'd5;

    localparam logic [1:0] REG_TABLE  = 2'd0;
    localparam logic [1:0] REG_DOMAIN = 2'd1;
    localparam logic [1:0] REG_SPROT  = 2'd2;
    localparam logic [1:0] REG_RPROT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_READ, ST_WALK1, ST_WALK2
    } back_state_t;

    typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND} walk_phase_t;

    // One queued word from front to back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] vaddr;
        logic        is_read;
        logic        user_mode;
        logic [31:0] descriptor;
    } item_t;

    function automatic logic [21:0] kind_mask(input logic [2:0] k);
        unique case (k) inside
            PK_SMALL, PK_XSMALL: kind_mask = 22'h3FFFFC;
            PK_LARGE: kind_mask = 22'h3FFFC0;
            PK_SECT:  kind_mask = 22'h3FFC00;
            PK_TINY:  kind_mask = 22'h3FFFFF;
            default:  kind_mask = 22'h0;
        endcase
    endfunction
endpackage

// ----- rtl/mtw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_front
// Takes command words and holds them in a two-deep queue for the back end.
// ----------------------------------------------------------------------------
module mtw_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtw_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output mtw_pkg::item_t head
);
    import mtw_pkg::*;

    item_t      q_reg [2];
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_item;
    end

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = q_reg[rd_reg];
endmodule

// ----- rtl/mtw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_back
// Searches the buffer one entry a cycle, runs the walk and checks access.
// ----------------------------------------------------------------------------
`include "mmu_tlb_walk_access_check_core_assert.svh"
module mtw_back #(
    parameter int TLB_ENTRIES = mtw_pkg::TLB_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  mtw_pkg::item_t head,
    output logic           pop,
    input  logic [31:0]    table_base,
    input  logic [31:0]    domain_access,
    input  logic           system_protect,
    input  logic           rom_protect,
    output logic           res_valid,
    output logic           res_kind,
    output logic [31:0]    res_read_addr,
    output logic [31:0]    res_paddr,
    output logic [2:0]     res_fault,
    output logic [2:0]     res_page_kind
);
    import mtw_pkg::*;

    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [IW:0] LAST = (IW+1)'(TLB_ENTRIES - 1);

    // Entry memories are read through registers; validity lives in flops so
    // that a full invalidation clears every entry at once.
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [2:0]  mem_kind [TLB_ENTRIES];
    logic [21:0] mem_virt [TLB_ENTRIES];
    logic [21:0] mem_phys [TLB_ENTRIES];
    logic [11:0] mem_perm [TLB_ENTRIES];
    logic [3:0]  mem_dom  [TLB_ENTRIES];

    back_state_t st_reg, st_next;
    walk_phase_t ph_reg, ph_next;
    logic [IW-1:0] ptr_reg, ptr_next, idx_reg, idx_next;
    logic [31:0] pva_reg, pva_next, sdesc_reg, sdesc_next;
    logic        prd_reg, prd_next, pusr_reg, pusr_next;
    item_t       cur_reg, cur_next;
    logic [21:0] rv_reg, rp_reg;
    logic [11:0] rperm_reg;
    logic [3:0]  rdom_reg;
    logic [2:0]  rk_reg;

    logic        o_v_reg, o_v_next, o_k_reg, o_k_next;
    logic [31:0] o_ra_reg, o_ra_next, o_pa_reg, o_pa_next;
    logic [2:0]  o_f_reg, o_f_next, o_pk_reg, o_pk_next;

    logic        wr_en, hit, chk_en;
    logic [IW-1:0] wr_idx;
    logic [2:0]  wr_kind, chk_kind;
    logic [21:0] wr_virt, wr_phys, chk_phys;
    logic [11:0] wr_perm, chk_perm;
    logic [3:0]  wr_dom, chk_dom;
    logic [31:0] chk_va;
    logic        chk_rd, chk_usr;
    logic [21:0] m;
    logic        clr_one, clr_all;
    logic [2:0]  ck;

    // Access check of one entry, used for hits and for fresh fills.
    always_comb
    begin
        logic [1:0] acc, sub, ap;
        logic [21:0] cm;
        logic ok;
        acc = 2'(domain_access >> {chk_dom, 1'b0});
        cm  = kind_mask(chk_kind);
        case (chk_kind)
            PK_TINY:  sub = 2'd0;
            PK_LARGE: sub = chk_va[15:14];
            PK_SECT:  sub = 2'd3;
            default:  sub = chk_va[11:10];
        endcase
        ap = 2'(chk_perm >> (4'(sub) * 4'd2 + 4'd4));
        case (ap)
            2'd0: ok = chk_rd && ((system_protect && !chk_usr) || rom_protect);
            2'd1: ok = !chk_usr;
            2'd2: ok = chk_rd || !chk_usr;
            default: ok = 1'b1;
        endcase
        ck = F_NONE;
        if (acc == 2'd0 || acc == 2'd2)
            ck = F_DOMAIN;
        else if (acc == 2'd1 && !ok)
            ck = (chk_kind == PK_SECT) ? F_SPERM : F_PPERM;
        m = cm;
    end

    always_comb
    begin
        logic [21:0] em;
        st_next = st_reg; ph_next = ph_reg; ptr_next = ptr_reg; idx_next = idx_reg;
        pva_next = pva_reg; prd_next = prd_reg; pusr_next = pusr_reg;
        sdesc_next = sdesc_reg; cur_next = cur_reg;
        o_v_next = 1'b0; o_k_next = 1'b1; o_ra_next = '0; o_pa_next = '0;
        o_f_next = F_NONE; o_pk_next = PK_NONE;
        pop = 1'b0; wr_en = 1'b0; wr_idx = ptr_reg; wr_kind = PK_NONE;
        wr_virt = '0; wr_phys = '0; wr_perm = '0; wr_dom = '0;
        chk_en = 1'b0; chk_kind = rk_reg; chk_phys = rp_reg; chk_perm = rperm_reg;
        chk_dom = rdom_reg; chk_va = cur_reg.vaddr; chk_rd = cur_reg.is_read;
        chk_usr = cur_reg.user_mode; clr_one = 1'b0; clr_all = 1'b0;
        // The read registers hold the entry at idx_reg throughout a search.
        em = kind_mask(rk_reg);
        hit = valid_reg[idx_reg] && (em != '0)
              && ((cur_reg.vaddr[31:10] & em) == (rv_reg & em));
        unique case (st_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    pop = 1'b1;
                    cur_next = head;
                    idx_next = '0;
                    unique case (head.kind) inside
                        KIND_ACCESS, KIND_INV: st_next = ST_SEARCH;
                        KIND_DESC:
                        begin
                            if (ph_reg == PH_FIRST) st_next = ST_WALK1;
                            else if (ph_reg == PH_SECOND) st_next = ST_WALK2;
                        end
                        default: clr_all = 1'b1;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    if (cur_reg.kind == KIND_INV)
                    begin
                        clr_one = 1'b1;
                        st_next = ST_IDLE;
                    end
                    else
                        st_next = ST_READ;
                end
                else if ({1'b0, idx_reg} == LAST)
                begin
                    st_next = ST_IDLE;
                    if (cur_reg.kind == KIND_ACCESS)
                    begin
                        ph_next = PH_FIRST;
                        pva_next = cur_reg.vaddr;
                        prd_next = cur_reg.is_read;
                        pusr_next = cur_reg.user_mode;
                        o_v_next = 1'b1; o_k_next = 1'b0;
                        o_ra_next = {table_base[31:14], cur_reg.vaddr[31:20], 2'b00};
                    end
                end
                else
                    idx_next = idx_reg + IW'(1);
                if (cur_reg.kind == KIND_ACCESS && (hit || {1'b0, idx_reg} == LAST))
                    ph_next = hit ? PH_IDLE : PH_FIRST;
            end
            ST_READ:
            begin
                chk_en = 1'b1;
                st_next = ST_IDLE;
            end
            ST_WALK1:
            begin
                logic [31:0] d;
                d = cur_reg.descriptor;
                st_next = ST_IDLE;
                unique case (d[1:0])
                    2'd0:
                    begin
                        ph_next = PH_IDLE;
                        o_v_next = 1'b1; o_f_next = F_STRANS;
                    end
                    2'd2:
                    begin
                        ph_next = PH_IDLE;
                        wr_en = 1'b1; wr_kind = PK_SECT; wr_dom = d[8:5];
                        wr_perm = d[11:0] & 12'hC0C;
                    end
                    2'd1:
                    begin
                        sdesc_next = d; ph_next = PH_SECOND;
                        o_v_next = 1'b1; o_k_next = 1'b0;
                        o_ra_next = {d[31:10], pva_reg[19:12], 2'b00};
                    end
                    default:
                    begin
                        sdesc_next = d; ph_next = PH_SECOND;
                        o_v_next = 1'b1; o_k_next = 1'b0;
                        o_ra_next = {d[31:12], pva_reg[19:10], 2'b00};
                    end
                endcase
            end
            ST_WALK2:
            begin
                logic [31:0] d;
                d = cur_reg.descriptor;
                st_next = ST_IDLE;
                ph_next = PH_IDLE;
                wr_dom = sdesc_reg[8:5];
                wr_perm = d[11:0] & 12'hFFC;
                case (d[1:0])
                    2'd1: wr_kind = PK_LARGE;
                    2'd2: wr_kind = PK_SMALL;
                    2'd3: wr_kind = (sdesc_reg[1:0] == 2'd3) ? PK_TINY : PK_NONE;
                    default: wr_kind = PK_NONE;
                endcase
                if (wr_kind == PK_NONE)
                begin
                    o_v_next = 1'b1; o_f_next = F_PTRANS;
                end
                else
                    wr_en = 1'b1;
            end
            default: st_next = ST_IDLE;
        endcase
        if (wr_en)
        begin
            wr_virt = pva_reg[31:10] & kind_mask(wr_kind);
            wr_phys = cur_reg.descriptor[31:10] & kind_mask(wr_kind);
            ptr_next = ({1'b0, ptr_reg} == LAST) ? '0 : ptr_reg + IW'(1);
            chk_en = 1'b1; chk_kind = wr_kind; chk_phys = wr_phys; chk_perm = wr_perm;
            chk_dom = wr_dom; chk_va = pva_reg; chk_rd = prd_reg; chk_usr = pusr_reg;
        end
        if (clr_all)
            ptr_next = '0;
        if (chk_en)
        begin
            o_v_next = 1'b1; o_k_next = 1'b1; o_f_next = ck; o_pk_next = chk_kind;
            o_pa_next = (ck != F_NONE) ? 32'd0
                      : {(chk_phys & m) | (chk_va[31:10] & ~m), chk_va[9:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; ph_reg <= PH_IDLE; ptr_reg <= '0; o_v_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; ph_reg <= ph_next; ptr_reg <= ptr_next;
            o_v_reg <= o_v_next;
            if (clr_all)
                valid_reg <= '0;
            else if (clr_one)
                valid_reg[idx_reg] <= 1'b0;
            else if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; pva_reg <= pva_next; prd_reg <= prd_next;
        pusr_reg <= pusr_next; sdesc_reg <= sdesc_next; cur_reg <= cur_next;
        o_k_reg <= o_k_next; o_ra_reg <= o_ra_next; o_pa_reg <= o_pa_next;
        o_f_reg <= o_f_next; o_pk_reg <= o_pk_next;
        if (wr_en)
        begin
            mem_kind[wr_idx] <= wr_kind;
            mem_virt[wr_idx] <= wr_virt; mem_phys[wr_idx] <= wr_phys;
            mem_perm[wr_idx] <= wr_perm; mem_dom[wr_idx] <= wr_dom;
        end
        rv_reg <= mem_virt[idx_next]; rp_reg <= mem_phys[idx_next];
        rperm_reg <= mem_perm[idx_next]; rdom_reg <= mem_dom[idx_next];
        rk_reg <= mem_kind[idx_next];
    end

    assign res_valid = o_v_reg; assign res_kind = o_k_reg;
    assign res_read_addr = o_ra_reg; assign res_paddr = o_pa_reg;
    assign res_fault = o_f_reg; assign res_page_kind = o_pk_reg;

    `MTW_ASSERT_IMP(a_req_clean, clk, rst_n, o_v_reg && !o_k_reg,
        o_f_reg == F_NONE && o_pa_reg == 32'd0, "request carries a fault")
    `MTW_ASSERT_IMP(a_fault_no_pa, clk, rst_n, o_v_reg && o_f_reg != F_NONE,
        o_pa_reg == 32'd0, "faulted completion carries an address")
    `MTW_ASSERT_NEXT(a_read_done, clk, rst_n, st_reg == ST_READ,
        o_v_reg && o_k_reg, "hit gave no completion")
endmodule

// ----- rtl/mmu_tlb_walk_access_check_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmu_tlb_walk_access_check_core
// Translation buffer with two-level table walk and access permission check.
// ----------------------------------------------------------------------------
// Channel   Handshake            Direction
// command   start / busy         in
// result    result_valid strobe  out
// config    cfg_we, cfg_index    in
// A lookup reads one entry a cycle through a registered read port: an access
// gives its result after the search, passing through the read state on a hit.
// A descriptor with a walk pending gives its result after the walk state;
// invalidate all and invalidate entry give no result.
// A two-word queue sits between command intake and the back end; busy rises
// while it is full. Reset clears the valid flag of every entry at once.
// The receiver cannot stall: each result is shown for one cycle only.
module mmu_tlb_walk_access_check_core #(
    parameter int TLB_ENTRIES = mtw_pkg::TLB_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] vaddr,
    input  logic        is_read,
    input  logic        user_mode,
    input  logic [31:0] descriptor,
    output logic        result_valid,
    output logic        result_kind,
    output logic [31:0] read_addr,
    output logic [31:0] paddr,
    output logic [2:0]  fault,
    output logic [2:0]  page_kind,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mtw_pkg::*;

    logic [31:0] table_base_reg, domain_reg;
    logic        sprot_reg, rprot_reg;
    logic        full, pop, not_empty;
    item_t       in_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0; domain_reg <= '0; sprot_reg <= 1'b0; rprot_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE:  table_base_reg <= cfg_data;
                REG_DOMAIN: domain_reg <= cfg_data;
                REG_SPROT:  sprot_reg <= cfg_data[0];
                default:    rprot_reg <= cfg_data[0];
            endcase
        end
    end

    assign in_item = '{kind: kind, vaddr: vaddr, is_read: is_read,
                       user_mode: user_mode, descriptor: descriptor};
    assign busy = full;

    mtw_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_item(in_item),
        .full(full), .pop(pop), .not_empty(not_empty), .head(head)
    );

    mtw_back #(.TLB_ENTRIES(TLB_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
        .table_base(table_base_reg), .domain_access(domain_reg),
        .system_protect(sprot_reg), .rom_protect(rprot_reg),
        .res_valid(result_valid), .res_kind(result_kind), .res_read_addr(read_addr),
        .res_paddr(paddr), .res_fault(fault), .res_page_kind(page_kind)
    );
endmodule
